FILE: rtl/core/cot_pkg.sv
// Shared constants and types for the cell ownership table.
package cot_pkg;

  localparam int CELLS   = 4096;
  localparam int IDX_W   = 12;
  localparam int OWNER_W = 8;
  localparam int LIMIT_W = 13;
  localparam int TYPE_W  = 2;

  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [OWNER_W-1:0] owner_t;
  typedef logic [LIMIT_W-1:0] limit_t;
  typedef logic [TYPE_W-1:0]  req_t;

  localparam req_t REQ_CLAIM   = 2'd0;
  localparam req_t REQ_REPLACE = 2'd1;
  localparam req_t REQ_RELEASE = 2'd2;
  localparam req_t REQ_LOAD    = 2'd3;

  localparam owner_t EMPTY_OWNER = '0;
  localparam idx_t   LAST_IDX    = idx_t'(CELLS - 1);
  localparam limit_t RESET_LIMIT = limit_t'(CELLS);

endpackage

FILE: rtl/core/cot_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cot_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/cell_ownership_table_top.sv
// Top level of the cell ownership table: compare-and-swap owner store.
//
// Each word on the input is one request (claim, replace, release, load) on
// one cell of a 4096-entry table of 8-bit owners. A request is taken when
// start is high and busy is low; its result appears on out_success and
// out_resident with out_strobe high for one cycle, once the request has
// passed stage 1 and the result register. The receiver cannot hold results
// off, and none are buffered: every strobe must be taken. Requests may be
// issued back to back, one per cycle while busy is low; the owner store is
// a single RAM with registered read data, and a request that hits the cell
// written by the request just ahead of it gets that value forwarded. After
// reset, busy stays high while a clearing pass writes every cell to empty,
// one cell a cycle. cells_in_use may be written at any time through the cfg_
// channel (always ready) but should only change while no request is in flight.
module cell_ownership_table_top (
  input  logic                    clk,
  input  logic                    rst_n,
  // request channel
  input  logic                    start,
  output logic                    busy,
  input  cot_pkg::req_t           in_req_type,
  input  cot_pkg::idx_t           in_cell_index,
  input  cot_pkg::owner_t         in_owner,
  input  cot_pkg::owner_t         in_expected,
  // result channel
  output logic                    out_strobe,
  output logic                    out_success,
  output cot_pkg::owner_t         out_resident,
  // configuration
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  cot_pkg::limit_t         cfg_cells_in_use
);

  // ---------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------
  cot_pkg::limit_t limit_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= cot_pkg::RESET_LIMIT;
    end else if (cfg_valid && cfg_ready) begin
      limit_r <= cfg_cells_in_use;
    end
  end

  // ---------------------------------------------------------------------
  // Clearing pass after reset: one cell a cycle, busy until done
  // ---------------------------------------------------------------------
  logic          clr_active_r;
  cot_pkg::idx_t clr_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
    end else if (clr_active_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == cot_pkg::LAST_IDX) begin
        clr_active_r <= 1'b0;
      end
    end
  end

  assign busy = clr_active_r;

  logic accept;
  assign accept = start && !busy;

  // ---------------------------------------------------------------------
  // RAM and its write port (clear pass or stage-1 write back)
  // ---------------------------------------------------------------------
  logic            s1_we;
  cot_pkg::owner_t s1_wdata;
  logic            ram_we;
  cot_pkg::idx_t   ram_waddr;
  cot_pkg::owner_t ram_wdata;
  cot_pkg::owner_t ram_rdata;

  cot_ram #(
    .WIDTH (cot_pkg::OWNER_W),
    .DEPTH (cot_pkg::CELLS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (in_cell_index),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------------
  // Stage 1: request held while the read is in flight
  // ---------------------------------------------------------------------
  logic            s1_valid_r;
  cot_pkg::req_t   s1_type_r;
  cot_pkg::idx_t   s1_idx_r;
  cot_pkg::owner_t s1_owner_r;
  cot_pkg::owner_t s1_expected_r;
  logic            s1_in_range_r;
  logic            s1_fwd_hit_r;
  cot_pkg::owner_t s1_fwd_data_r;

  assign ram_we    = clr_active_r || s1_we;
  assign ram_waddr = clr_active_r ? clr_addr_r : s1_idx_r;
  assign ram_wdata = clr_active_r ? cot_pkg::EMPTY_OWNER : s1_wdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
  end

  // payload: no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_type_r     <= in_req_type;
      s1_idx_r      <= in_cell_index;
      s1_owner_r    <= in_owner;
      s1_expected_r <= in_expected;
      // index is 12 bits, limit 13: a limit of CELLS or more lets every index in
      s1_in_range_r <= {1'b0, in_cell_index} < limit_r;
      // RAM read overlaps this cycle's write of the same cell: forward it
      s1_fwd_hit_r  <= s1_we && (s1_idx_r == in_cell_index);
      s1_fwd_data_r <= s1_wdata;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1 compare-and-swap decision
  // ---------------------------------------------------------------------
  cot_pkg::owner_t cur;
  logic            ok_nxt;
  cot_pkg::owner_t held_nxt;
  logic            hit;

  assign cur = s1_fwd_hit_r ? s1_fwd_data_r : ram_rdata;

  always_comb begin
    ok_nxt   = 1'b0;
    held_nxt = cot_pkg::EMPTY_OWNER;
    hit      = 1'b0;
    s1_wdata = s1_owner_r;
    priority if (!s1_in_range_r) begin
      ok_nxt = 1'b0;
    end else if (s1_type_r == cot_pkg::REQ_LOAD) begin
      ok_nxt   = 1'b1;
      held_nxt = cur;
    end else if (s1_owner_r == cot_pkg::EMPTY_OWNER) begin
      ok_nxt = 1'b0;
    end else begin
      held_nxt = cur;
      unique case (s1_type_r)
        cot_pkg::REQ_CLAIM:   hit = (cur == cot_pkg::EMPTY_OWNER);
        cot_pkg::REQ_REPLACE: hit = (cur == s1_expected_r);
        cot_pkg::REQ_RELEASE: begin
          hit      = (cur == s1_owner_r);
          s1_wdata = cot_pkg::EMPTY_OWNER;
        end
        default:              hit = 1'b0;
      endcase
      ok_nxt = hit;
    end
  end

  assign s1_we = s1_valid_r && hit;

  // ---------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------
  logic            out_strobe_r;
  logic            out_success_r;
  cot_pkg::owner_t out_resident_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      out_success_r  <= ok_nxt;
      out_resident_r <= held_nxt;
    end
  end

  assign out_strobe   = out_strobe_r;
  assign out_success  = out_success_r;
  assign out_resident = out_resident_r;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> ##1 out_strobe)
    else $error("request without result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |=> !out_strobe)
    else $error("result without request");

  a_out_of_range: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_in_range_r |=> !out_success && out_resident == cot_pkg::EMPTY_OWNER)
    else $error("out-of-range request not rejected");

  a_clear_complete: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(clr_active_r) |-> $past(clr_addr_r) == cot_pkg::LAST_IDX)
    else $error("clearing pass ended early");

  a_no_write_oob: assert property (@(posedge clk) disable iff (!rst_n)
    s1_we |-> s1_in_range_r && !clr_active_r)
    else $error("write back on rejected request");

endmodule
